@@ hw/rtl/lmbst_pkg.sv @@
package lmbst_pkg;

  localparam int unsigned MaxLightsDefault = 32;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned RadiusW  = 31;
  localparam int unsigned SlotW    = 5;
  localparam int unsigned GridW    = 8;
  localparam int unsigned LevelW   = 4;
  localparam int unsigned MaskW    = 32;
  localparam int unsigned SizeW    = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [SizeW-1:0] SquareSizeReset = 16'd256;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_TEST  = 1'b1
  } opcode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SQUARE_SIZE = 2'd0,
    CFG_ORIGIN_X    = 2'd1,
    CFG_ORIGIN_Y    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic [RadiusW-1:0]       reach;
  } light_t;

endpackage

@@ hw/rtl/lmbst_if.sv @@
interface lmbst_req_if import lmbst_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic [SlotW-1:0]         light_slot;
  logic signed [CoordW-1:0] light_x;
  logic signed [CoordW-1:0] light_y;
  logic signed [CoordW-1:0] light_z;
  logic [RadiusW-1:0]       light_radius;
  logic [GridW-1:0]         square_col;
  logic [GridW-1:0]         square_row;
  logic [LevelW-1:0]        square_level;
  logic signed [CoordW-1:0] min_height;
  logic signed [CoordW-1:0] max_height;
  logic [MaskW-1:0]         candidate_mask;

  modport source (
    output valid, opcode, light_slot, light_x, light_y, light_z, light_radius,
           square_col, square_row, square_level, min_height, max_height,
           candidate_mask,
    input  ready
  );
  modport sink (
    input  valid, opcode, light_slot, light_x, light_y, light_z, light_radius,
           square_col, square_row, square_level, min_height, max_height,
           candidate_mask,
    output ready
  );
endinterface

interface lmbst_rsp_if import lmbst_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [MaskW-1:0] hit_mask;

  modport source (output valid, hit_mask, input ready);
  modport sink (input valid, hit_mask, output ready);
endinterface

@@ hw/rtl/light_mask_box_sphere_test_unit.sv @@
// Light mask box/sphere test. The unit holds a table of MAX_LIGHTS point lights in one
// synchronous memory and, for a test request, reports which of the candidate lights reach
// an axis-aligned terrain box (squared-distance compare, exact signed Q24.8 arithmetic).
// A light write returns a zero mask through the result register; the table reads as all
// zero after reset. A test forms the box bounds in the SETUP and BOUNDS states, reads one
// table entry per cycle on the single memory read port, drains the gap/square/sum pipeline
// and then loads the result register once the result slot is free. A new request is taken
// while a finished result still waits, except a write, which needs the result slot.
module light_mask_box_sphere_test_unit import lmbst_pkg::*; #(
  parameter int unsigned MAX_LIGHTS = MaxLightsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  lmbst_req_if.sink           req_i,
  lmbst_rsp_if.source         rsp_o
);

  localparam int unsigned IdxW  = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
  localparam int unsigned CW    = 35;           // box bound width
  localparam int unsigned GW    = CW + 1;       // axis gap width
  localparam int unsigned ProdW = 2 * RadiusW;
  localparam int unsigned SumW  = ProdW + 2;
  localparam int unsigned OffW  = GridW + SizeW;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SETUP  = 6'b000010,
    ST_BOUNDS = 6'b000100,
    ST_WALK   = 6'b001000,
    ST_DRAIN  = 6'b010000,
    ST_DONE   = 6'b100000
  } state_e;

  function automatic logic [GW-1:0] axis_gap(input logic signed [GW-1:0] p,
                                             input logic signed [GW-1:0] lo,
                                             input logic signed [GW-1:0] hi);
    logic [GW-1:0] g;
    if (p < lo) begin
      g = GW'(lo - p);
    end else if (p > hi) begin
      g = GW'(p - hi);
    end else begin
      g = '0;
    end
    return g;
  endfunction

  state_e state_q, state_d;

  logic [SizeW-1:0]         sq_size_q;
  logic signed [CoordW-1:0] origin_x_q, origin_y_q;

  logic [GridW-1:0]         col_q, row_q;
  logic [LevelW-1:0]        level_q;
  logic signed [CoordW-1:0] zlo_q, zhi_q;
  logic [MAX_LIGHTS-1:0]    cand_q;
  logic signed [CW-1:0]     xlo_q, ylo_q, xhi_q, yhi_q;
  logic [RadiusW-1:0]       edge_q;

  light_t                   light_mem [MAX_LIGHTS];
  logic [MAX_LIGHTS-1:0]    entry_vld_q;
  light_t                   rd_data_q;
  logic [IdxW-1:0]          addr_q;

  logic                     s1_vld_q, s1_cand_q;
  logic [IdxW-1:0]          s1_idx_q;
  logic                     s2_vld_q, s2_ok_q;
  logic [IdxW-1:0]          s2_idx_q;
  logic [RadiusW-1:0]       gx_q, gy_q, gz_q, r_q;
  logic                     s3_vld_q, s3_ok_q;
  logic [IdxW-1:0]          s3_idx_q;
  logic [ProdW-1:0]         sx_q, sy_q, sz_q, rr_q;

  logic [MAX_LIGHTS-1:0]    hits_q;
  logic                     rsp_vld_q;
  logic [MaskW-1:0]         hit_mask_q;

  logic                     req_fire, wr_fire, test_fire, rsp_free, issue, last_addr;
  logic                     wr_in_range;
  logic [OffW-1:0]          col_off, row_off;
  logic [RadiusW-1:0]       edge_len;
  logic [GW-1:0]            dx, dy, dz, reach_ext;
  logic                     far;
  logic [SumW-1:0]          dist_sq;
  logic                     hit;

  assign rsp_free  = !rsp_vld_q || rsp_o.ready;
  assign req_i.ready = (state_q == ST_IDLE) && ((req_i.opcode == OP_TEST) || rsp_free);
  assign req_fire  = req_i.valid && req_i.ready;
  assign wr_fire   = req_fire && (req_i.opcode == OP_WRITE);
  assign test_fire = req_fire && (req_i.opcode == OP_TEST);
  assign wr_in_range = int'(req_i.light_slot) < MAX_LIGHTS;
  assign issue     = (state_q == ST_WALK);
  assign last_addr = (addr_q == IdxW'(MAX_LIGHTS - 1));

  assign rsp_o.valid    = rsp_vld_q;
  assign rsp_o.hit_mask = hit_mask_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_size_q  <= SquareSizeReset;
      origin_x_q <= '0;
      origin_y_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SQUARE_SIZE: sq_size_q  <= cfg_data_i[SizeW-1:0];
        CFG_ORIGIN_X:    origin_x_q <= $signed(cfg_data_i[CoordW-1:0]);
        CFG_ORIGIN_Y:    origin_y_q <= $signed(cfg_data_i[CoordW-1:0]);
        default: ;
      endcase
    end
  end

  // Controller.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (test_fire) state_d = ST_SETUP;
      ST_SETUP:  state_d = ST_BOUNDS;
      ST_BOUNDS: state_d = ST_WALK;
      ST_WALK:   if (last_addr) state_d = ST_DRAIN;
      ST_DRAIN:  if (!s1_vld_q && !s2_vld_q && !s3_vld_q) state_d = ST_DONE;
      ST_DONE:   if (rsp_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      addr_q  <= '0;
    end else begin
      state_q <= state_d;
      if (test_fire) begin
        addr_q <= '0;
      end else if (issue && !last_addr) begin
        addr_q <= addr_q + IdxW'(1);
      end
    end
  end

  // Test request capture.
  always_ff @(posedge clk_i) begin
    if (test_fire) begin
      col_q   <= req_i.square_col;
      row_q   <= req_i.square_row;
      level_q <= req_i.square_level;
      zlo_q   <= req_i.min_height;
      zhi_q   <= req_i.max_height;
      cand_q  <= req_i.candidate_mask[MAX_LIGHTS-1:0];
    end
  end

  // Box bounds: lower corner first, then the far corner from the edge length.
  assign col_off  = OffW'(col_q) * OffW'(sq_size_q);
  assign row_off  = OffW'(row_q) * OffW'(sq_size_q);
  assign edge_len = RadiusW'(sq_size_q) << level_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SETUP) begin
      xlo_q  <= CW'($signed({1'b0, col_off})) + CW'(origin_x_q);
      ylo_q  <= CW'($signed({1'b0, row_off})) + CW'(origin_y_q);
      edge_q <= edge_len;
    end
    if (state_q == ST_BOUNDS) begin
      xhi_q <= xlo_q + CW'($signed({1'b0, edge_q}));
      yhi_q <= ylo_q + CW'($signed({1'b0, edge_q}));
    end
  end

  // Light table.
  always_ff @(posedge clk_i) begin
    if (wr_fire && wr_in_range) begin
      light_mem[req_i.light_slot[IdxW-1:0]] <= '{x:     req_i.light_x,
                                                y:     req_i.light_y,
                                                z:     req_i.light_z,
                                                reach: req_i.light_radius};
    end
    if (issue) begin
      rd_data_q <= light_mem[addr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_vld_q <= '0;
    end else if (wr_fire && wr_in_range) begin
      entry_vld_q[req_i.light_slot[IdxW-1:0]] <= 1'b1;
    end
  end

  // Axis gaps against the box; an entry never written counts as a zero-radius light.
  assign dz = axis_gap(GW'(rd_data_q.z), GW'(zlo_q), GW'(zhi_q));
  assign dx = axis_gap(GW'(rd_data_q.x), GW'(xlo_q), GW'(xhi_q));
  assign dy = axis_gap(GW'(rd_data_q.y), GW'(ylo_q), GW'(yhi_q));
  assign reach_ext = GW'(rd_data_q.reach);
  assign far = (dx >= reach_ext) || (dy >= reach_ext) || (dz >= reach_ext);

  assign dist_sq = SumW'(sx_q) + SumW'(sy_q) + SumW'(sz_q);
  assign hit     = s3_ok_q && (dist_sq < SumW'(rr_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= issue;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_cand_q <= cand_q[addr_q] && entry_vld_q[addr_q];
    s1_idx_q  <= addr_q;

    s2_ok_q  <= s1_cand_q && !far;
    s2_idx_q <= s1_idx_q;
    gx_q     <= dx[RadiusW-1:0];
    gy_q     <= dy[RadiusW-1:0];
    gz_q     <= dz[RadiusW-1:0];
    r_q      <= rd_data_q.reach;

    s3_ok_q  <= s2_ok_q;
    s3_idx_q <= s2_idx_q;
    sx_q     <= ProdW'(gx_q) * ProdW'(gx_q);
    sy_q     <= ProdW'(gy_q) * ProdW'(gy_q);
    sz_q     <= ProdW'(gz_q) * ProdW'(gz_q);
    rr_q     <= ProdW'(r_q) * ProdW'(r_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q <= '0;
    end else if (test_fire) begin
      hits_q <= '0;
    end else if (s3_vld_q && hit) begin
      hits_q[s3_idx_q] <= 1'b1;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q  <= 1'b0;
      hit_mask_q <= '0;
    end else if (wr_fire) begin
      rsp_vld_q  <= 1'b1;
      hit_mask_q <= '0;
    end else if ((state_q == ST_DONE) && rsp_free) begin
      rsp_vld_q  <= 1'b1;
      hit_mask_q <= MaskW'(hits_q);
    end else if (rsp_o.ready) begin
      rsp_vld_q  <= 1'b0;
    end
  end

endmodule

@@ hw/rtl/lmbst_checker.sv @@
module lmbst_checker import lmbst_pkg::*; #(
  parameter int unsigned MAX_LIGHTS = MaxLightsDefault
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             req_valid_i,
  input logic             req_ready_i,
  input logic             req_opcode_i,
  input logic             rsp_valid_i,
  input logic             rsp_ready_i,
  input logic [MaskW-1:0] rsp_hit_mask_i
);

  // A light write answers in the next cycle with an empty mask.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && (req_opcode_i == OP_WRITE)
      |=> rsp_valid_i && (rsp_hit_mask_i == '0))
    else $error("write transfer not answered by a zero mask");

  // A test closes the request side once it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && (req_opcode_i == OP_TEST) |=> !req_ready_i)
    else $error("request taken during a test");

  // A write is never taken while the result register is blocked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i && req_valid_i && req_ready_i
      |-> (req_opcode_i == OP_TEST))
    else $error("write taken while the result slot is full");

  // Lights beyond the table never report a hit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> ((rsp_hit_mask_i >> MAX_LIGHTS) == '0))
    else $error("hit reported beyond the light table");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_hit_mask_i))
    else $error("stalled result changed");

endmodule

bind light_mask_box_sphere_test_unit lmbst_checker #(.MAX_LIGHTS(MAX_LIGHTS)) u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .req_opcode_i   (req_i.opcode),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .rsp_hit_mask_i (rsp_o.hit_mask)
);

@@ tb/tb_light_mask_box_sphere_test_unit.sv @@
module tb_light_mask_box_sphere_test_unit import lmbst_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StuckLimit   = 4000;
  localparam int unsigned SettleCycles = 80;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned PhaseItems   = 245;
  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 2'd3;

  typedef struct packed {
    opcode_e                  op;
    logic [SlotW-1:0]         slot;
    logic signed [CoordW-1:0] lx;
    logic signed [CoordW-1:0] ly;
    logic signed [CoordW-1:0] lz;
    logic [RadiusW-1:0]       radius;
    logic [GridW-1:0]         col;
    logic [GridW-1:0]         row;
    logic [LevelW-1:0]        level;
    logic signed [CoordW-1:0] zmin;
    logic signed [CoordW-1:0] zmax;
    logic [MaskW-1:0]         mask;
  } unit_req_t;

  // Mirrors the light table and registers, and keeps the hit masks still owed by the unit.
  class light_reach_predictor;
    light_t                   light_tbl [MaxLightsDefault];
    logic [SizeW-1:0]         sq_size;
    logic signed [CoordW-1:0] org_x;
    logic signed [CoordW-1:0] org_y;
    logic [MaskW-1:0]         expected_hit_masks [$];
    int unsigned              errors;
    int unsigned              writes_seen;
    int unsigned              tests_seen;
    int unsigned              hits_seen;
    int unsigned              regs_written;

    function new();
      foreach (light_tbl[i]) light_tbl[i] = '0;
      sq_size = SquareSizeReset;
      org_x = '0;
      org_y = '0;
      errors = 0;
      writes_seen = 0;
      tests_seen = 0;
      hits_seen = 0;
      regs_written = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_SQUARE_SIZE: sq_size = data[SizeW-1:0];
        CFG_ORIGIN_X:    org_x = data;
        CFG_ORIGIN_Y:    org_y = data;
        default: ;
      endcase
      regs_written++;
    endfunction

    function int unsigned pending();
      return expected_hit_masks.size();
    endfunction

    // Low bound is tested first, so an inverted range still gives a defined gap.
    function bit [63:0] gap_to_span(longint p, longint lo, longint hi);
      if (p < lo) return 64'(lo - p);
      if (p > hi) return 64'(p - hi);
      return '0;
    endfunction

    function void note_request(unit_req_t r);
      longint           xlo, ylo, xhi, yhi, zlo, zhi, span;
      bit [63:0]        rch, dx, dy, dz;
      logic [MaskW-1:0] hits;
      if (r.op == OP_WRITE) begin
        if (r.slot < MaxLightsDefault) begin
          light_tbl[r.slot].x     = r.lx;
          light_tbl[r.slot].y     = r.ly;
          light_tbl[r.slot].z     = r.lz;
          light_tbl[r.slot].reach = r.radius;
        end
        writes_seen++;
        expected_hit_masks.push_back('0);
        return;
      end
      span = longint'(sq_size) << r.level;
      xlo  = longint'(r.col) * longint'(sq_size) + longint'(org_x);
      ylo  = longint'(r.row) * longint'(sq_size) + longint'(org_y);
      xhi  = xlo + span;
      yhi  = ylo + span;
      zlo  = longint'(r.zmin);
      zhi  = longint'(r.zmax);
      hits = '0;
      for (int i = 0; i < MaxLightsDefault; i++) begin
        if (r.mask[i]) begin
          rch = 64'(light_tbl[i].reach);
          dx  = gap_to_span(longint'($signed(light_tbl[i].x)), xlo, xhi);
          dy  = gap_to_span(longint'($signed(light_tbl[i].y)), ylo, yhi);
          dz  = gap_to_span(longint'($signed(light_tbl[i].z)), zlo, zhi);
          // A single axis gap at or past the reach already rules the light out,
          // and it keeps the squares below from overflowing.
          if (dx < rch && dy < rch && dz < rch) begin
            if (dx * dx + dy * dy + dz * dz < rch * rch) hits[i] = 1'b1;
          end
        end
      end
      tests_seen++;
      hits_seen += $countones(hits);
      expected_hit_masks.push_back(hits);
    endfunction

    function void check_hit_mask(logic [MaskW-1:0] got);
      logic [MaskW-1:0] want;
      if (expected_hit_masks.size() == 0) begin
        errors++;
        $display("%0t: unexpected hit_mask transfer, expected none, got %08h", $time, got);
        return;
      end
      want = expected_hit_masks.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: hit_mask mismatch, expected %08h, got %08h", $time, want, got);
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  lmbst_req_if req_if ();
  lmbst_rsp_if rsp_if ();

  light_mask_box_sphere_test_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  light_reach_predictor sb;
  int unsigned          send_idle_pct;
  int unsigned          recv_idle_pct;
  int unsigned          hold_len;
  int unsigned          stuck_cycles;

  // Current register values and the grid cell each light was placed near, for stimulus.
  logic [SizeW-1:0]         cur_size;
  logic signed [CoordW-1:0] cur_ox;
  logic signed [CoordW-1:0] cur_oy;
  logic [GridW-1:0]         placed_col [MaxLightsDefault];
  logic [GridW-1:0]         placed_row [MaxLightsDefault];

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Output side: random stalls, plus a long hold-off when one is requested.
  initial begin
    rsp_if.ready = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_len != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (hold_len) @(posedge clk_i);
        hold_len = 0;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) sb.check_hit_mask(rsp_if.hit_mask);
      if ((rsp_if.valid && rsp_if.ready) || (req_if.valid && req_if.ready)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= StuckLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, stuck_cycles);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic send_req(input unit_req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid          <= 1'b1;
    req_if.opcode         <= r.op;
    req_if.light_slot     <= r.slot;
    req_if.light_x        <= r.lx;
    req_if.light_y        <= r.ly;
    req_if.light_z        <= r.lz;
    req_if.light_radius   <= r.radius;
    req_if.square_col     <= r.col;
    req_if.square_row     <= r.row;
    req_if.square_level   <= r.level;
    req_if.min_height     <= r.zmin;
    req_if.max_height     <= r.zmax;
    req_if.candidate_mask <= r.mask;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(r);
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Writes all three registers and then the unused index, which must change nothing.
  task automatic program_regs(input logic [SizeW-1:0] size, input logic [CfgDataW-1:0] ox,
                              input logic [CfgDataW-1:0] oy);
    logic [CfgDataW-1:0] size_word;
    logic [CfgDataW-1:0] junk;
    size_word = {16'($urandom()), size};
    junk = $urandom();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_SQUARE_SIZE;
    cfg_data_i <= size_word;
    @(posedge clk_i);
    sb.write_reg(CFG_SQUARE_SIZE, size_word);
    cfg_idx_i  <= CFG_ORIGIN_X;
    cfg_data_i <= ox;
    @(posedge clk_i);
    sb.write_reg(CFG_ORIGIN_X, ox);
    cfg_idx_i  <= CFG_ORIGIN_Y;
    cfg_data_i <= oy;
    @(posedge clk_i);
    sb.write_reg(CFG_ORIGIN_Y, oy);
    cfg_idx_i  <= CfgIdxUnused;
    cfg_data_i <= junk;
    @(posedge clk_i);
    sb.write_reg(CfgIdxUnused, junk);
    cfg_we_i <= 1'b0;
    cur_size = size;
    cur_ox = ox;
    cur_oy = oy;
  endtask

  function automatic unit_req_t light_req(int unsigned slot, logic [31:0] x, logic [31:0] y,
                                          logic [31:0] z, logic [30:0] rad);
    unit_req_t r;
    r = '0;
    r.op = OP_WRITE;
    r.slot = 5'(slot);
    r.lx = x;
    r.ly = y;
    r.lz = z;
    r.radius = rad;
    return r;
  endfunction

  function automatic unit_req_t box_req(int unsigned col, int unsigned row, int unsigned lvl,
                                        logic [31:0] zmin, logic [31:0] zmax,
                                        logic [31:0] mask);
    unit_req_t r;
    r = '0;
    r.op = OP_TEST;
    r.col = 8'(col);
    r.row = 8'(row);
    r.level = 4'(lvl);
    r.zmin = zmin;
    r.zmax = zmax;
    r.mask = mask;
    return r;
  endfunction

  // Mostly places the light a few squares around a random grid cell, with a random reach.
  function automatic unit_req_t rand_light(int unsigned slot);
    unit_req_t   r;
    longint      sz;
    int unsigned zspan;
    r = '0;
    r.op = OP_WRITE;
    r.slot = 5'(slot);
    sz = longint'(cur_size);
    zspan = 4 * cur_size + 16;
    placed_col[slot] = 8'($urandom());
    placed_row[slot] = 8'($urandom());
    if ($urandom_range(0, 99) < 85) begin
      r.lx = 32'(longint'(cur_ox) + longint'(placed_col[slot]) * sz +
                 longint'($urandom_range(0, 5 * cur_size)) - 2 * sz);
      r.ly = 32'(longint'(cur_oy) + longint'(placed_row[slot]) * sz +
                 longint'($urandom_range(0, 5 * cur_size)) - 2 * sz);
      r.lz = 32'(longint'($urandom_range(0, 2 * zspan)) - longint'(zspan));
      if ($urandom_range(0, 99) < 5) r.radius = '0;
      else r.radius = 31'($urandom_range(0, 3 * cur_size + 16));
    end else begin
      r.lx = $urandom();
      r.ly = $urandom();
      r.lz = $urandom();
      r.radius = 31'($urandom());
    end
    return r;
  endfunction

  // Mostly aims the box at a placed light; the rest is unconstrained noise.
  function automatic unit_req_t rand_test();
    unit_req_t   r;
    int unsigned s, pick, zspan;
    longint      zlo;
    r = '0;
    r.op = OP_TEST;
    zspan = 4 * cur_size + 16;
    if ($urandom_range(0, 99) < 12) begin
      r.col = 8'($urandom());
      r.row = 8'($urandom());
      r.level = 4'($urandom());
      r.zmin = $urandom();
      r.zmax = $urandom();
      r.mask = $urandom();
    end else begin
      s = $urandom_range(0, MaxLightsDefault - 1);
      r.col = 8'(placed_col[s] + $urandom_range(0, 4) - 2);
      r.row = 8'(placed_row[s] + $urandom_range(0, 4) - 2);
      pick = $urandom_range(0, 99);
      if (pick < 85) r.level = 4'($urandom_range(0, 3));
      else if (pick < 95) r.level = 4'($urandom_range(4, 8));
      else r.level = 4'($urandom_range(9, 15));
      zlo = longint'($urandom_range(0, zspan)) - longint'(zspan);
      r.zmin = 32'(zlo);
      if ($urandom_range(0, 99) < 6) r.zmax = 32'(zlo - longint'($urandom_range(1, zspan)));
      else r.zmax = 32'(zlo + longint'($urandom_range(0, 2 * zspan)));
      pick = $urandom_range(0, 99);
      if (pick < 20) r.mask = '1;
      else if (pick < 40) r.mask = 32'b1 << s;
      else r.mask = $urandom();
    end
    return r;
  endfunction

  task automatic run_directed();
    // Table is clear after reset, so nothing can hit yet.
    send_req(box_req(0, 0, 0, -256, 256, '1));
    send_req(light_req(0, 128, 128, 0, 1));
    // A gap exactly equal to the reach is a miss; one more unit of reach is a hit.
    send_req(light_req(1, -256, 128, 0, 256));
    send_req(light_req(2, -256, 128, 0, 257));
    send_req(light_req(3, 128, 128, 0, 0));
    send_req(light_req(4, 128, 128, 50, 60));
    send_req(light_req(31, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF));
    send_req(light_req(30, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF));
    send_req(box_req(0, 0, 0, -10, 10, '1));
    // Inverted height range.
    send_req(box_req(0, 0, 0, 100, -100, '1));
    send_req(box_req(255, 255, 15, 32'h8000_0000, 32'h7FFF_FFFF, '1));
    send_req(box_req(0, 0, 8, -10, 10, '0));
    send_req(box_req(0, 0, 1, -10, 10, 32'h8000_0001));
    send_req(box_req(0, 255, 15, 32'h8000_0000, 32'h7FFF_FFFF, 32'hC000_0000));
    drain_results();
    // Degenerate box, with origin x at its most negative and origin y at its most positive.
    program_regs('0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_req(light_req(5, 32'h8000_0000, 32'h7FFF_FFFF, 0, 2));
    send_req(box_req(0, 0, 3, -1, 1, '1));
    send_req(box_req(255, 0, 15, 32'h8000_0000, 32'h7FFF_FFFF, '1));
    drain_results();
    program_regs('1, 32'h7FFF_FFFF, 32'h8000_0000);
    send_req(box_req(255, 255, 15, 32'h8000_0000, 32'h7FFF_FFFF, '1));
    send_req(box_req(0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, '1));
    send_req(light_req(6, 32'h7FFF_FFFF, 32'h8000_0000, 0, 31'h7FFF_FFFF));
    send_req(box_req(1, 1, 2, -1000, 1000, 32'h0000_0040));
  endtask

  task automatic run_random_phase(input int unsigned ph);
    logic [SizeW-1:0] size;
    logic [31:0]      ox, oy;
    drain_results();
    size = 16'($urandom_range(1, 4096));
    ox = 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
    oy = 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
    case (ph)
      1: begin
        size = 16'd1;
        ox = 32'h8000_0000;
        oy = 32'h8000_0000;
      end
      2: size = '1;
      3: begin
        size = '0;
        ox = 32'h7FFF_FFFF;
        oy = 32'h7FFF_FFFF;
      end
      default: ;
    endcase
    program_regs(size, ox, oy);
    send_idle_pct = (ph < 2) ? 25 : (ph < 4) ? 45 : 0;
    recv_idle_pct = (ph < 2) ? 45 : (ph < 4) ? 25 : 0;
    for (int unsigned s = 0; s < MaxLightsDefault; s++) send_req(rand_light(s));
    for (int unsigned k = 0; k < PhaseItems; k++) begin
      // The output side stops for a long stretch while requests keep coming.
      if (ph == 1 && k == 100) hold_len = HoldCycles;
      if (ph == 3 && k == 150) begin
        req_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk_i);
      end
      if ($urandom_range(0, 99) < 22) send_req(rand_light($urandom_range(0, 31)));
      else send_req(rand_test());
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_SQUARE_SIZE;
    cfg_data_i = '0;
    req_if.valid = 1'b0;
    req_if.opcode = OP_WRITE;
    req_if.light_slot = '0;
    req_if.light_x = '0;
    req_if.light_y = '0;
    req_if.light_z = '0;
    req_if.light_radius = '0;
    req_if.square_col = '0;
    req_if.square_row = '0;
    req_if.square_level = '0;
    req_if.min_height = '0;
    req_if.max_height = '0;
    req_if.candidate_mask = '0;
    sb = new();
    cur_size = SquareSizeReset;
    cur_ox = '0;
    cur_oy = '0;
    foreach (placed_col[i]) begin
      placed_col[i] = '0;
      placed_row[i] = '0;
    end
    send_idle_pct = 25;
    recv_idle_pct = 45;
    hold_len = 0;
    stuck_cycles = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    for (int unsigned ph = 0; ph < 6; ph++) run_random_phase(ph);
    drain_results();
    $display("Checked %0d light writes and %0d box tests, %0d lights in reach in total.",
             sb.writes_seen, sb.tests_seen, sb.hits_seen);
    $display("Register writes: %0d, with slow sender, slow receiver, long output stall.",
             sb.regs_written);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/lmbst_pkg.sv
hw/rtl/lmbst_if.sv
hw/rtl/light_mask_box_sphere_test_unit.sv
hw/rtl/lmbst_checker.sv
tb/tb_light_mask_box_sphere_test_unit.sv
